### hw/rtl/yee_fdtd_e_field_update_xz_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef YEE_FDTD_E_FIELD_UPDATE_XZ_MACROS_SVH
`define YEE_FDTD_E_FIELD_UPDATE_XZ_MACROS_SVH

// Checked at every rising edge outside of reset.
`define YEE_CHK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define YEE_CHK_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### hw/rtl/yee_eup_pkg.sv
`default_nettype none
package yee_eup_pkg;

  localparam int MAX_ROW   = 512;
  localparam int COL_W     = $clog2(MAX_ROW);
  localparam int FIELD_W   = 32;
  localparam int COEF_W    = 31;
  localparam int CFRAC     = 24;
  localparam int DIFF_W    = FIELD_W + 1;
  localparam int PROD_W    = COEF_W + 1 + DIFF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_IN    = 9;
  localparam int IN_W      = NUM_IN * FIELD_W;
  localparam int OUT_W     = 3 * FIELD_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COURANT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT_Z = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP = 2'd2;

  localparam logic signed [SUM_W-1:0] RND_HALF =
    {{(SUM_W-CFRAC){1'b0}}, 1'b1, {(CFRAC-1){1'b0}}};

  localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  function automatic logic signed [DIFF_W-1:0] fdiff(input logic signed [FIELD_W-1:0] a,
                                                     input logic signed [FIELD_W-1:0] b);
    logic signed [DIFF_W-1:0] aw;
    logic signed [DIFF_W-1:0] bw;
    aw = {a[FIELD_W-1], a};
    bw = {b[FIELD_W-1], b};
    return aw - bw;
  endfunction

  function automatic logic signed [PROD_W-1:0] cmul(input logic [COEF_W-1:0] c,
                                                    input logic signed [DIFF_W-1:0] d);
    logic signed [COEF_W:0] cs;
    cs = {1'b0, c};
    return cs * d;
  endfunction

  function automatic logic signed [SUM_W-1:0] pext(input logic signed [PROD_W-1:0] p);
    return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  function automatic logic signed [SUM_W-1:0] fext(input logic signed [FIELD_W-1:0] e);
    return {{(SUM_W-FIELD_W-CFRAC){e[FIELD_W-1]}}, e, {CFRAC{1'b0}}};
  endfunction

  function automatic logic [FIELD_W-1:0] sat_round(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-CFRAC-1:0] q;
    logic [SUM_W-CFRAC-FIELD_W:0] top;
    q   = s[SUM_W-1:CFRAC];
    top = q[SUM_W-CFRAC-1:FIELD_W-1];
    if ((&top) || !(|top)) begin
      return q[FIELD_W-1:0];
    end else if (q[SUM_W-CFRAC-1]) begin
      return FIELD_MIN;
    end else begin
      return FIELD_MAX;
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/yee_fdtd_e_field_update_xz.sv
// An accepted cell is registered in turn as inputs, products, sums and result.
// Throughput: one cell per cycle without backpressure; the row buffer is read and
// written once per accepted cell; backpressure stalls only the full stages.
// Reset clears the coefficients, the previous-cell registers, the column
// counter and all stage valid bits; the row buffer is not cleared.
`default_nettype none
module yee_fdtd_e_field_update_xz import yee_eup_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // ex_in, ey_in, ez_in, hx_cell, hy_cell, hz_cell, jx_cell, jy_cell, jz_cell
  input  wire logic [IN_W-1:0]      s_tdata,
  // row_start, first_row
  input  wire logic [1:0]           s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // ex_out, ey_out, ez_out
  output logic [OUT_W-1:0]          m_tdata,
  // updated
  output logic [0:0]                m_tuser,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  logic [COEF_W-1:0] courant_x;
  logic [COEF_W-1:0] courant_z;
  logic [COEF_W-1:0] half_step;

  logic [COL_W-1:0]          column_index;
  logic [COL_W-1:0]          col;
  logic signed [FIELD_W-1:0] prev_hy;
  logic signed [FIELD_W-1:0] prev_hz;

  logic [2*FIELD_W-1:0] row_mem [MAX_ROW];
  logic [2*FIELD_W-1:0] row_rd;

  logic signed [FIELD_W-1:0] in_f [NUM_IN];
  logic in_acc;
  logic in_ghost;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1, v2, v3, v4;

  logic signed [FIELD_W-1:0] e1 [3];
  logic signed [FIELD_W-1:0] h1 [3];
  logic signed [FIELD_W-1:0] j1 [3];
  logic signed [FIELD_W-1:0] hy_left1;
  logic signed [FIELD_W-1:0] hz_left1;
  logic ghost1;

  logic signed [FIELD_W-1:0] e2 [3];
  logic signed [PROD_W-1:0] pzy2, pjx2, pzx2, pxz2, pjy2, pxy2, pjz2;
  logic ghost2;

  logic signed [FIELD_W-1:0] e3 [3];
  logic signed [SUM_W-1:0] a3 [3];
  logic signed [SUM_W-1:0] b3 [3];
  logic ghost3;

  logic [FIELD_W-1:0] res4 [3];
  logic upd4;

  always_comb begin
    for (int i = 0; i < NUM_IN; i++) begin
      in_f[i] = s_tdata[i*FIELD_W +: FIELD_W];
    end
  end

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign in_acc   = s_tvalid && s_tready;
  assign in_ghost = s_tuser[0] || s_tuser[1];
  assign col      = s_tuser[0] ? '0 : column_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      courant_x <= '0;
      courant_z <= '0;
      half_step <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COURANT_X: courant_x <= cfg_data;
        REG_COURANT_Z: courant_z <= cfg_data;
        REG_HALF_STEP: half_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      prev_hy      <= '0;
      prev_hz      <= '0;
    end else if (in_acc) begin
      column_index <= (col == COL_W'(MAX_ROW - 1)) ? '0 : col + COL_W'(1);
      prev_hy      <= in_f[4];
      prev_hz      <= in_f[5];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_rd       <= row_mem[col];
      row_mem[col] <= {in_f[4], in_f[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_acc;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= in_f[i];
        h1[i] <= in_f[3+i];
        j1[i] <= in_f[6+i];
      end
      hy_left1 <= prev_hy;
      hz_left1 <= prev_hz;
      ghost1   <= in_ghost;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      e2     <= e1;
      ghost2 <= ghost1;
      pzy2   <= cmul(courant_z, fdiff(row_rd[2*FIELD_W-1:FIELD_W], h1[1]));
      pjx2   <= cmul(half_step, fdiff('0, j1[0]));
      pzx2   <= cmul(courant_z, fdiff(h1[0], row_rd[FIELD_W-1:0]));
      pxz2   <= cmul(courant_x, fdiff(hz_left1, h1[2]));
      pjy2   <= cmul(half_step, fdiff('0, j1[1]));
      pxy2   <= cmul(courant_x, fdiff(h1[1], hy_left1));
      pjz2   <= cmul(half_step, fdiff('0, j1[2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      e3     <= e2;
      ghost3 <= ghost2;
      a3[0]  <= fext(e2[0]) + RND_HALF + pext(pzy2);
      b3[0]  <= pext(pjx2);
      a3[1]  <= fext(e2[1]) + RND_HALF + pext(pzx2);
      b3[1]  <= pext(pxz2) + pext(pjy2);
      a3[2]  <= fext(e2[2]) + RND_HALF + pext(pxy2);
      b3[2]  <= pext(pjz2);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      for (int i = 0; i < 3; i++) begin
        res4[i] <= ghost3 ? e3[i] : sat_round(a3[i] + b3[i]);
      end
      upd4 <= !ghost3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {res4[2], res4[1], res4[0]};
  assign m_tuser  = upd4;

endmodule
`default_nettype wire

### hw/rtl/yee_eup_chk.sv
`default_nettype none
`include "yee_fdtd_e_field_update_xz_macros.svh"
module yee_eup_chk import yee_eup_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic [0:0]       m_tuser
);

  // A result that is not taken stays on the port unchanged.
  `YEE_CHK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser}))

  // Reset empties every stage, so nothing is shown after it.
  `YEE_CHK_ALL(a_reset_empty, clk, rst |=> !m_tvalid && s_tready)

  // With the output register empty no stage can block the input.
  `YEE_CHK(a_empty_ready, clk, rst, !m_tvalid |-> s_tready)

  // Right after reset no result can show before the pipeline has filled.
  `YEE_CHK(a_no_early_out, clk, rst, $fell(rst) |-> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)

endmodule

bind yee_fdtd_e_field_update_xz yee_eup_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
